// ===== src/sidec_pkg.sv =====
`default_nettype none

package sidec_pkg;

  // ASCII codes used in the output text
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Digit store: ten entries cover every 32-bit magnitude
  localparam int              NUM_DIGITS = 10;
  localparam int              DIGIT_AW   = $clog2(NUM_DIGITS);
  localparam logic [DIGIT_AW-1:0] LAST_SLOT = DIGIT_AW'(NUM_DIGITS - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input item, take its magnitude
    logic divide;     // peel off one decimal digit
    logic put_sign;   // load '-' into the output register
    logic put_digit;  // load the next digit, most significant first
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic neg;        // the captured value is negative
    logic div_done;   // the digit peeled this cycle is the last one
    logic slot_free;  // the output register can take a character this cycle
    logic idx_zero;   // the digit about to go out is the least significant
  } sts_t;

endpackage

`default_nettype wire

// ===== src/sidec_dp.sv =====
`default_nettype none

module sidec_dp (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [31:0]       value_i,
  input  sidec_pkg::cmd_t   cmd_i,
  output sidec_pkg::sts_t   sts_o,
  input  wire               out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        character_o,
  output logic              last_o
);

  logic [31:0]                     mag_q;
  logic                            neg_q;
  logic [3:0]                      digits_q [sidec_pkg::NUM_DIGITS];
  logic [sidec_pkg::DIGIT_AW-1:0]  nd_q;
  logic [sidec_pkg::DIGIT_AW-1:0]  idx_q;
  logic                            out_valid_q;
  logic [7:0]                      char_q;
  logic                            last_q;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;
  logic [31:0] mag_in;
  logic        slot_free;
  logic        put;

  // Magnitude of the input as unsigned, so the most negative value is safe
  assign mag_in = value_i[31] ? (32'd0 - value_i) : value_i;

  // Divide by ten through the reciprocal, remainder by shift-add and subtract
  assign prod     = 64'(mag_q) * 64'(sidec_pkg::RECIP_TEN);
  assign quot     = {3'd0, prod[63:sidec_pkg::RECIP_SHIFT]};
  assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
  assign rem_full = mag_q - quot_x10;

  assign slot_free = !out_valid_q || out_ready_i;
  assign put       = cmd_i.put_sign || cmd_i.put_digit;

  // Status back to the controller
  always_comb begin
    sts_o.neg       = neg_q;
    sts_o.div_done  = (quot == 32'd0) || (nd_q == sidec_pkg::LAST_SLOT);
    sts_o.slot_free = slot_free;
    sts_o.idx_zero  = (idx_q == '0);
  end

  // Conversion registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_in;
      neg_q <= value_i[31];
      nd_q  <= '0;
    end else if (cmd_i.divide) begin
      digits_q[nd_q] <= rem_full[3:0];
      mag_q          <= quot;
      idx_q          <= nd_q;
      nd_q           <= nd_q + 1'b1;
    end else if (cmd_i.put_digit) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_sign) begin
      char_q <= sidec_pkg::CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.put_digit) begin
      char_q <= sidec_pkg::CHAR_ZERO + {4'd0, digits_q[idx_q]};
      last_q <= (idx_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== src/sidec_ctrl.sv =====
`default_nettype none

module sidec_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  sidec_pkg::sts_t  sts_i,
  output sidec_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.divide = 1'b1;
        if (sts_i.div_done) begin
          state_d = sts_i.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.put_sign = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.put_digit = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_unit.sv =====
// Sequence: the item is taken, the shared divide-by-ten step peels off its D digits (D = 1..10)
//   least significant first, then the sign if negative and the digits leave most significant first.
// Flow: a new item is taken only after the last character of the current one is loaded into
//   the output register; with out_ready_i held high, one character leaves per cycle.
// Reset: rst_ni asynchronous, active low; clears the controller and the output valid.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] value_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  sidec_pkg::cmd_t cmd;
  sidec_pkg::sts_t sts;

  sidec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sidec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Only minus or a decimal digit ever goes out
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == sidec_pkg::CHAR_MINUS) ||
                    ((character_o >= 8'h30) && (character_o <= 8'h39)))
    else $error("illegal character on output");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (character_o == sidec_pkg::CHAR_MINUS)) |-> !last_o)
    else $error("minus flagged as last");

  // An accepted item blocks the input until its conversion is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after accept");

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ===== tb/signed_int_to_decimal_ascii_unit_test.sv =====
`default_nettype none

module signed_int_to_decimal_ascii_unit_test;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [31:0] value_i     = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  character_o;
  logic        last_o;

  logic [31:0] pending_values[$];
  text_char_t  expected_text[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // sender pacing
  int          burst_left = 1;
  int          gap_left   = 0;

  // receiver stall pattern
  int          ready_mode      = 0;
  int          ready_mode_left = 0;
  int          ready_phase     = 0;
  int          ready_period    = 2;

  signed_int_to_decimal_ascii_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decimal text of one value: optional sign, then digits, most significant first
  function automatic void queue_decimal_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digit[10];
    int          count;
    text_char_t  c;
    mag   = value[31] ? (32'd0 - value) : value;
    count = 0;
    do begin
      digit[count] = 4'(mag % 32'd10);
      mag          = mag / 32'd10;
      count++;
    end while (mag != 32'd0 && count < 10);
    if (value[31]) begin
      c.code = sidec_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      c.code = sidec_pkg::CHAR_ZERO + 8'(digit[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Random value: full-range bits, a chosen digit count, powers of ten, or extremes
  function automatic logic [31:0] random_value();
    int          kind;
    int          ndig;
    bit          neg;
    longint      lo;
    longint      hi;
    longint      mag;
    longint      p10;
    logic [31:0] corner[7];
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
               32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    kind = $urandom_range(0, 9);
    neg  = $urandom_range(0, 1);
    if (kind <= 3) begin
      return $urandom;
    end else if (kind <= 7) begin
      ndig = $urandom_range(1, 10);
      p10  = 1;
      for (int i = 1; i < ndig; i++) p10 = p10 * 10;
      lo  = (ndig == 1) ? 0 : p10;
      hi  = (ndig == 10) ? (64'd2147483647 + neg) : (p10 * 10 - 1);
      mag = lo + (longint'($urandom) % (hi - lo + 1));
      return neg ? 32'(-mag) : 32'(mag);
    end else if (kind == 8) begin
      ndig = $urandom_range(0, 9);
      p10  = 1;
      for (int i = 0; i < ndig; i++) p10 = p10 * 10;
      mag  = p10 + $urandom_range(0, 2) - 1;
      return neg ? 32'(-mag) : 32'(mag);
    end
    return corner[$urandom_range(0, 6)];
  endfunction

  // Sender: bursts of items from the pending queue, random gaps between bursts
  always @(posedge clk_i) begin : feed_items
    logic        nxt_valid;
    logic [31:0] nxt_value;
    nxt_valid = in_valid_i;
    nxt_value = value_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        nxt_valid = 1'b0;
        nxt_value = $urandom;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_values.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_value = pending_values.pop_front();
        end
      end
    end
    in_valid_i <= nxt_valid;
    value_i    <= nxt_value;
  end

  // Receiver: switch between always ready, coin flip, mostly stalled, periodic
  always @(posedge clk_i) begin : pace_receiver
    logic nxt_ready;
    if (ready_mode_left <= 0) begin
      ready_mode      = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(20, 200);
      ready_period    = $urandom_range(2, 7);
      ready_phase     = 0;
    end
    ready_mode_left--;
    ready_phase = (ready_phase + 1) % ready_period;
    case (ready_mode)
      0: nxt_ready = 1'b1;
      1: nxt_ready = $urandom_range(0, 1);
      2: nxt_ready = ($urandom_range(0, 3) == 0);
      default: nxt_ready = (ready_phase == 0);
    endcase
    out_ready_i <= nxt_ready;
  end

  // Monitor: predict on each accepted item, check each accepted character
  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) queue_decimal_text(value_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h last %b", character_o, last_o);
          error_count++;
        end else begin
          want = expected_text.pop_front();
          if (character_o !== want.code) begin
            $error("character: expected %h actual %h", want.code, character_o);
            error_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %b actual %b", want.last, last_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : run_test
    // directed: zero, one digit, digit-count boundaries, both extremes
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(-32'sd9);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'h7FFF_FFFE);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000001);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'd1234567890);
    pending_values.push_back(-32'sd1234567890);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd7);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_values.push_back(random_value());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample away from the rising edge
    @(negedge clk_i);
    while (pending_values.size() > 0 || in_valid_i || expected_text.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && expected_text.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
